// ----- rtl/itoa_pkg.sv -----
// Shared constants, types and helpers for the integer to ASCII converter.
`default_nettype none

package itoa_pkg;

    localparam int VALUE_BITS = 32;
    // 1233/4096 approximates log10(2)
    localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int DIG_N      = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIG_W      = 4 * DIG_N;
    localparam int CNT_W      = $clog2(DIG_N + 1);
    localparam int BIT_W      = $clog2(VALUE_BITS);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_X     = 8'h78;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_A     = 8'h61;
    localparam logic [3:0] RADIX_DEC   = 4'd10;

    typedef struct packed {
        logic                  hex;
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PFX0,
        ST_PFX_X,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } t_state;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d < RADIX_DEC) begin
            return ASCII_ZERO + {4'b0000, d};
        end else begin
            return ASCII_A + {4'b0000, d} - {4'b0000, RADIX_DEC};
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/integer_to_ascii_converter_core.sv -----
// Top level of the integer to ASCII converter: front end, queue and digit engine.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  command  | i_start / o_busy       | i_req_type, i_value[31:0]
//  result   | o_strobe (one cycle)   | o_char_code[7:0], o_last
//
// Engine per item: a pop from ST_IDLE, then for decimal a double-dabble pass over all 32 bits
// (one bit each) and a sign beat if negative; for hex the prefix beats '0' and 'x'. Leading
// zero digits are then skipped and the rest are sent; each item first passes the front register.
// The queue lets the next command enter while the engine works; o_busy rises when the
// front register and queue are full. The receiver cannot stall the engine.
// Reset is synchronous and empties everything.
`default_nettype none

module integer_to_ascii_converter_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_req_type,
    input  wire logic [31:0] i_value,
    output logic             o_strobe,
    output logic [7:0]       o_char_code,
    output logic             o_last
);

    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_empty;
    itoa_pkg::t_item w_fitem;
    itoa_pkg::t_item w_qitem;

    itoa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req_type),
        .i_value    (i_value),
        .i_q_full   (w_full),
        .o_busy     (o_busy),
        .o_push     (w_push),
        .o_item     (w_fitem)
    );

    itoa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_qitem)
    );

    itoa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_empty),
        .i_q_item    (w_qitem),
        .o_pop       (w_pop),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// ----- rtl/itoa_front.sv -----
// Front end: takes a command beat, classifies sign and mode, forms the magnitude.
`default_nettype none

module itoa_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_req_type,
    input  wire logic [31:0]                   i_value,
    input  wire logic                          i_q_full,
    output logic                               o_busy,
    output logic                               o_push,
    output itoa_pkg::t_item                    o_item
);

    logic                            r_vld;
    logic                            n_vld;
    itoa_pkg::t_item                 r_item;
    itoa_pkg::t_item                 n_item;
    logic [itoa_pkg::VALUE_BITS-1:0] w_val;
    logic                            w_take;

    assign o_busy = r_vld && i_q_full;
    assign o_push = r_vld && !i_q_full;
    assign o_item = r_item;
    assign w_take = i_start && !o_busy;
    assign w_val  = itoa_pkg::VALUE_BITS'(i_value);

    always_comb begin
        n_item     = r_item;
        n_vld      = r_vld;
        if (w_take) begin
            n_vld      = 1'b1;
            n_item.hex = i_req_type;
            n_item.neg = !i_req_type && w_val[itoa_pkg::VALUE_BITS-1];
            // most negative value wraps to itself, which is the right magnitude
            n_item.mag = n_item.neg ? (~w_val + 1'b1) : w_val;
        end else if (o_push) begin
            n_vld      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

`default_nettype wire

// ----- rtl/itoa_queue.sv -----
// Two-entry queue between the front end and the digit engine.
`default_nettype none

module itoa_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire itoa_pkg::t_item  i_item,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output itoa_pkg::t_item       o_item
);

    itoa_pkg::t_item                r_mem [itoa_pkg::QDEPTH];
    logic [itoa_pkg::QPTR_W-1:0]    r_wr;
    logic [itoa_pkg::QPTR_W-1:0]    r_rd;
    logic [itoa_pkg::QCNT_W-1:0]    r_cnt;
    logic [itoa_pkg::QPTR_W-1:0]    n_wr;
    logic [itoa_pkg::QPTR_W-1:0]    n_rd;
    logic [itoa_pkg::QCNT_W-1:0]    n_cnt;
    logic                           w_wen;
    logic                           w_ren;

    assign o_full  = (r_cnt == itoa_pkg::QCNT_W'(itoa_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];
    assign w_wen   = i_push && !o_full;
    assign w_ren   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_wen) begin
            n_wr = (r_wr == itoa_pkg::QPTR_W'(itoa_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_ren) begin
            n_rd = (r_rd == itoa_pkg::QPTR_W'(itoa_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({w_wen, w_ren})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/itoa_back.sv -----
// Digit engine: double-dabble for decimal, then prefix, sign and digits one beat a cycle, no beat while skipping zeros.
`default_nettype none

module itoa_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_empty,
    input  wire itoa_pkg::t_item  i_q_item,
    output logic                  o_pop,
    output logic                  o_strobe,
    output logic [7:0]            o_char_code,
    output logic                  o_last
);

    itoa_pkg::t_state                r_state;
    itoa_pkg::t_state                n_state;
    logic                            r_neg;
    logic                            n_neg;
    logic [itoa_pkg::VALUE_BITS-1:0] r_bin;
    logic [itoa_pkg::VALUE_BITS-1:0] n_bin;
    logic [itoa_pkg::DIG_W-1:0]      r_dig;
    logic [itoa_pkg::DIG_W-1:0]      n_dig;
    logic [itoa_pkg::DIG_W-1:0]      w_adj;
    logic [itoa_pkg::BIT_W-1:0]      r_bitcnt;
    logic [itoa_pkg::BIT_W-1:0]      n_bitcnt;
    logic [itoa_pkg::CNT_W-1:0]      r_cnt;
    logic [itoa_pkg::CNT_W-1:0]      n_cnt;
    logic [3:0]                      w_top;
    logic                            w_lead0;

    assign w_top   = r_dig[itoa_pkg::DIG_W-1 -: 4];
    assign w_lead0 = (w_top == 4'd0) && (r_cnt > itoa_pkg::CNT_W'(1));

    // add-3 correction on every BCD digit before the shift
    always_comb begin
        for (int i = 0; i < itoa_pkg::DIG_N; i++) begin
            w_adj[4*i +: 4] = (r_dig[4*i +: 4] >= 4'd5) ? r_dig[4*i +: 4] + 4'd3
                                                         : r_dig[4*i +: 4];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itoa_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_q_item.hex ? itoa_pkg::ST_PFX0 : itoa_pkg::ST_CONV;
                end
            end
            itoa_pkg::ST_CONV: begin
                if (r_bitcnt == '0) begin
                    n_state = r_neg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_SKIP;
                end
            end
            itoa_pkg::ST_PFX0:  n_state = itoa_pkg::ST_PFX_X;
            itoa_pkg::ST_PFX_X: n_state = itoa_pkg::ST_SKIP;
            itoa_pkg::ST_SIGN:  n_state = itoa_pkg::ST_SKIP;
            itoa_pkg::ST_SKIP: begin
                if (!w_lead0) begin
                    n_state = itoa_pkg::ST_EMIT;
                end
            end
            itoa_pkg::ST_EMIT: begin
                if (r_cnt == itoa_pkg::CNT_W'(1)) begin
                    n_state = itoa_pkg::ST_IDLE;
                end
            end
            default: n_state = itoa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        o_strobe    = 1'b0;
        o_char_code = itoa_pkg::ASCII_ZERO;
        o_last      = 1'b0;
        unique case (r_state)
            itoa_pkg::ST_IDLE:  o_pop = !i_q_empty;
            itoa_pkg::ST_PFX0: begin
                o_strobe    = 1'b1;
                o_char_code = itoa_pkg::ASCII_ZERO;
            end
            itoa_pkg::ST_PFX_X: begin
                o_strobe    = 1'b1;
                o_char_code = itoa_pkg::ASCII_X;
            end
            itoa_pkg::ST_SIGN: begin
                o_strobe    = 1'b1;
                o_char_code = itoa_pkg::ASCII_MINUS;
            end
            itoa_pkg::ST_EMIT: begin
                o_strobe    = 1'b1;
                o_char_code = itoa_pkg::digit_char(w_top);
                o_last      = (r_cnt == itoa_pkg::CNT_W'(1));
            end
            default: ;
        endcase
    end

    always_comb begin
        n_neg    = r_neg;
        n_bin    = r_bin;
        n_dig    = r_dig;
        n_bitcnt = r_bitcnt;
        n_cnt    = r_cnt;
        case (r_state)
            itoa_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    n_neg    = i_q_item.neg;
                    n_bin    = i_q_item.mag;
                    n_bitcnt = itoa_pkg::BIT_W'(itoa_pkg::VALUE_BITS - 1);
                    n_cnt    = itoa_pkg::CNT_W'(itoa_pkg::DIG_N);
                    // hex nibbles are already digits
                    n_dig    = i_q_item.hex ? itoa_pkg::DIG_W'(i_q_item.mag) : '0;
                end
            end
            itoa_pkg::ST_CONV: begin
                n_dig    = {w_adj[itoa_pkg::DIG_W-2:0], r_bin[itoa_pkg::VALUE_BITS-1]};
                n_bin    = r_bin << 1;
                n_bitcnt = r_bitcnt - 1'b1;
            end
            itoa_pkg::ST_SKIP: begin
                if (w_lead0) begin
                    n_dig = r_dig << 4;
                    n_cnt = r_cnt - 1'b1;
                end
            end
            itoa_pkg::ST_EMIT: begin
                n_dig = r_dig << 4;
                n_cnt = r_cnt - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itoa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg    <= n_neg;
        r_bin    <= n_bin;
        r_dig    <= n_dig;
        r_bitcnt <= n_bitcnt;
        r_cnt    <= n_cnt;
    end

endmodule

`default_nettype wire

// ----- rtl/itoa_checker.sv -----
// Port-level checker for the converter, bound to the top level.
`default_nettype none

module itoa_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_strobe,
    input wire logic [7:0] i_char_code,
    input wire logic       i_last
);

    // nothing comes out the cycle after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_strobe)
        else $error("result beat right after reset");

    // 'x' of the hex prefix always directly follows its '0'
    a_prefix_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_strobe && !i_last && i_char_code == itoa_pkg::ASCII_X) |->
        ($past(i_strobe) && $past(i_char_code) == itoa_pkg::ASCII_ZERO && !$past(i_last)))
        else $error("hex prefix out of order");

    // a sign opens an item: it never directly follows a non-final beat
    a_sign_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_strobe && i_char_code == itoa_pkg::ASCII_MINUS) |->
        (!$past(i_strobe) || $past(i_last)))
        else $error("sign inside a number");

    // a final beat is a digit, never prefix or sign
    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_strobe && i_last) |->
        ((i_char_code >= itoa_pkg::ASCII_ZERO && i_char_code <= 8'h39) ||
         (i_char_code >= itoa_pkg::ASCII_A && i_char_code <= 8'h66)))
        else $error("final beat is not a digit");

endmodule

bind integer_to_ascii_converter_core itoa_checker u_itoa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_strobe    (o_strobe),
    .i_char_code (o_char_code),
    .i_last      (o_last)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for the integer to ASCII converter: directed and random commands, char checks.
`default_nettype none

module testbench;

    localparam logic MODE_DEC    = 1'b0;
    localparam logic MODE_HEX    = 1'b1;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   TAIL_CYCLES = 64;
    localparam int   PHASE_CMDS  = 110;

    typedef struct {
        logic        req_type;
        logic [31:0] value;
        int          idle_pct;
    } t_cmd;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_char_beat;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_start    = 1'b0;
    logic        i_req_type = 1'b0;
    logic [31:0] i_value    = '0;
    logic        o_busy;
    logic        o_strobe;
    logic [7:0]  o_char_code;
    logic        o_last;

    t_cmd       pending_cmds[$];
    t_char_beat expected_chars[$];
    int         cmds_taken  = 0;
    int         mismatches  = 0;
    int         cycle_count = 0;
    logic       beat_taken  = 1'b0;

    integer_to_ascii_converter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req_type  (i_req_type),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Renders one command into the characters the block should send.
    function automatic void push_rendered_chars(input logic req_type, input logic [31:0] value);
        logic [31:0] mag;
        logic [31:0] radix;
        logic [7:0]  d;
        logic [7:0]  text[$];
        logic [7:0]  digits[$];
        t_char_beat  beat;
        mag   = value;
        radix = (req_type == MODE_HEX) ? 32'd16 : 32'd10;
        if (req_type == MODE_HEX) begin
            text.push_back(itoa_pkg::ASCII_ZERO);
            text.push_back(itoa_pkg::ASCII_X);
        end
        if (mag == 0) begin
            text.push_back(itoa_pkg::ASCII_ZERO);
        end else begin
            // most negative value wraps to itself and prints as its unsigned magnitude
            if (req_type == MODE_DEC && mag[31]) begin
                text.push_back(itoa_pkg::ASCII_MINUS);
                mag = -mag;
            end
            while (mag != 0) begin
                d   = 8'(mag % radix);
                mag = mag / radix;
                digits.push_front((d < 10) ? itoa_pkg::ASCII_ZERO + d
                                           : itoa_pkg::ASCII_A + d - 8'd10);
            end
            foreach (digits[k]) text.push_back(digits[k]);
        end
        foreach (text[k]) begin
            beat.char_code = text[k];
            beat.last      = (k == text.size() - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    task automatic add_cmd(input logic req_type, input logic [31:0] value, input int idle_pct);
        t_cmd c;
        c.req_type = req_type;
        c.value    = value;
        c.idle_pct = idle_pct;
        pending_cmds.push_back(c);
    endtask

    // Driver: holds start until the beat is taken, then maybe idles.
    always @(negedge i_clk) begin
        t_cmd c;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || beat_taken) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= pending_cmds[0].idle_pct) begin
                c = pending_cmds.pop_front();
                i_start    <= 1'b1;
                i_req_type <= c.req_type;
                i_value    <= c.value;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: records accepted commands and checks each strobed char.
    always @(posedge i_clk) begin
        t_char_beat want;
        beat_taken = i_rst_n && i_start && !o_busy;
        if (beat_taken) begin
            push_rendered_chars(i_req_type, i_value);
            cmds_taken++;
        end
        if (i_rst_n && o_strobe) begin
            if (expected_chars.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected char 0x%02h last %0b", $time, o_char_code, o_last);
            end else begin
                want = expected_chars.pop_front();
                if (o_char_code !== want.char_code) begin
                    mismatches++;
                    $display("%0t: char_code expected 0x%02h actual 0x%02h",
                             $time, want.char_code, o_char_code);
                end
                if (o_last !== want.last) begin
                    mismatches++;
                    $display("%0t: last expected %0b actual %0b", $time, want.last, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int          idle_by_phase[4];
        int          total_cmds;
        logic [31:0] v;
        logic [31:0] p;
        logic        mode;
        idle_by_phase = '{0, 79, 25, 0};

        // zeros, sign extremes, digit-count boundaries, hex letter edges
        add_cmd(MODE_DEC, 32'd0, 0);
        add_cmd(MODE_HEX, 32'd0, 0);
        add_cmd(MODE_DEC, 32'h8000_0000, 0);
        add_cmd(MODE_DEC, 32'hFFFF_FFFF, 0);
        add_cmd(MODE_DEC, 32'h7FFF_FFFF, 0);
        add_cmd(MODE_HEX, 32'hFFFF_FFFF, 0);
        add_cmd(MODE_HEX, 32'h8000_0000, 0);
        add_cmd(MODE_HEX, 32'h7FFF_FFFF, 0);
        add_cmd(MODE_DEC, 32'd1, 0);
        add_cmd(MODE_HEX, 32'd1, 0);
        add_cmd(MODE_DEC, 32'd9, 0);
        add_cmd(MODE_DEC, 32'd10, 0);
        add_cmd(MODE_HEX, 32'h0000_000A, 0);
        add_cmd(MODE_HEX, 32'h0000_000F, 0);
        add_cmd(MODE_HEX, 32'h0000_0010, 0);
        add_cmd(MODE_DEC, 32'd999999999, 0);
        add_cmd(MODE_DEC, 32'd1000000000, 0);
        add_cmd(MODE_DEC, -32'sd10, 0);
        add_cmd(MODE_DEC, -32'sd1000000000, 0);
        add_cmd(MODE_HEX, 32'h0123_ABCD, 0);
        add_cmd(MODE_HEX, 32'hFEDC_BA98, 0);
        add_cmd(MODE_DEC, 32'h8000_0001, 0);

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < PHASE_CMDS; n++) begin
                mode = 1'($urandom_range(1));
                case ($urandom_range(3))
                    0: v = $urandom;
                    1: v = $urandom >> $urandom_range(31);
                    2: v = -($urandom >> $urandom_range(31));
                    default: begin
                        // near a power of the radix, where the digit count changes
                        p = 32'd1;
                        repeat ($urandom_range(mode ? 7 : 9)) p = p * (mode ? 32'd16 : 32'd10);
                        v = p + $urandom_range(2) - 32'd1;
                    end
                endcase
                add_cmd(mode, v, idle_by_phase[ph]);
            end
        end
        total_cmds = pending_cmds.size();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_taken < total_cmds) @(posedge i_clk);
        while (expected_chars.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/itoa_pkg.sv
rtl/itoa_front.sv
rtl/itoa_queue.sv
rtl/itoa_back.sv
rtl/integer_to_ascii_converter_core.sv
rtl/itoa_checker.sv
tb/testbench.sv
